FILE: rtl/core/aircraft_track_table_macros.svh
// Assertion macros shared by the track table modules.
`ifndef AIRCRAFT_TRACK_TABLE_MACROS_SVH
`define AIRCRAFT_TRACK_TABLE_MACROS_SVH

// Same-cycle implication, checked on clk, quiet during reset.
`define ATT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, quiet during reset.
`define ATT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/att_pkg.sv
// Shared types and constants of the aircraft track table.
package att_pkg;

    // Field widths
    localparam int ADDR_W    = 24;
    localparam int TIME_W    = 32;
    localparam int MSG_W     = 32;
    localparam int KIND_W    = 3;
    localparam int SLOT_W    = 5;
    localparam int USED_W    = 6;
    localparam int CFG_IDX_W = 2;

    // Default table size
    localparam int DEPTH_DEFAULT = 32;

    // Register reset values
    localparam logic [TIME_W-1:0] TTL_RESET = 32'd60000;
    localparam logic [TIME_W-1:0] PUB_RESET = 32'd1000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TTL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PUB = 2'd1;

    // Item operations
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_SCAN  = 1'b1;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_HIT     = 3'd0,
        KIND_NEW     = 3'd1,
        KIND_FULL    = 3'd2,
        KIND_EXPIRED = 3'd3,
        KIND_PUBLISH = 3'd4,
        KIND_DONE    = 3'd5
    } kind_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture the item and clear walk state
        logic rd_en;   // read the table at the read index
        logic cmp_en;  // read data for the compare index is valid
        logic finish;  // give the closing result of the item
    } att_cmd_t;

endpackage

FILE: rtl/core/att_ctrl.sv
// Controller: sequences the slot walk of one item.
module att_ctrl
    import att_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             hit,
    output logic             busy,
    output att_cmd_t         cmd,
    output logic [IDX_W-1:0] rd_idx,
    output logic [IDX_W-1:0] cmp_idx
);

`include "aircraft_track_table_macros.svh"

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_LAST,
        ST_FINAL
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             cmp_vld_reg, cmp_vld_next;

    // Next state: one read issued per cycle, each compared in the cycle after its read
    always_comb
    begin
        state_next   = state_reg;
        rd_idx_next  = rd_idx_reg;
        cmp_idx_next = cmp_idx_reg;
        cmp_vld_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next  = ST_WALK;
                    rd_idx_next = '0;
                end
            end
            ST_WALK:
            begin
                if (hit)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_idx_reg;
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        state_next = ST_LAST;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_LAST:
            begin
                state_next = hit ? ST_IDLE : ST_FINAL;
            end
            ST_FINAL:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_idx_reg  <= '0;
            cmp_idx_reg <= '0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_idx_reg  <= rd_idx_next;
            cmp_idx_reg <= cmp_idx_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    // Commands
    assign busy       = (state_reg != ST_IDLE);
    assign cmd.load   = start && (state_reg == ST_IDLE);
    assign cmd.rd_en  = (state_reg == ST_WALK);
    assign cmd.cmp_en = cmp_vld_reg;
    assign cmd.finish = (state_reg == ST_FINAL);
    assign rd_idx     = rd_idx_reg;
    assign cmp_idx    = cmp_idx_reg;

    `ATT_ASSERT_NEXT(a_hit_ends_walk, hit, (state_reg == ST_IDLE) && !cmp_vld_reg, "walk continued after a hit")
    `ATT_ASSERT_IMPL(a_finish_alone, cmd.finish, !cmd.rd_en && !cmd.cmp_en, "table access during finish")
    `ATT_ASSERT_IMPL(a_hit_needs_compare, hit, cmd.cmp_en, "hit without a compare")

endmodule

FILE: rtl/core/att_datapath.sv
// Datapath: slot table, configuration registers, compare logic, result register.
module att_datapath
    import att_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  att_cmd_t             cmd,
    input  logic [IDX_W-1:0]     rd_idx,
    input  logic [IDX_W-1:0]     cmp_idx,
    output logic                 hit,
    input  logic                 op,
    input  logic [ADDR_W-1:0]    address,
    input  logic [TIME_W-1:0]    now_ms,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_data,
    output logic                 result_valid,
    output logic [KIND_W-1:0]    kind,
    output logic [SLOT_W-1:0]    slot,
    output logic [ADDR_W-1:0]    entry_address,
    output logic [MSG_W-1:0]     message_count,
    output logic [USED_W-1:0]    used_count,
    output logic                 last
);

`include "aircraft_track_table_macros.svh"

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Configuration
    logic [TIME_W-1:0] ttl_reg, pub_int_reg;

    // Item held for the walk
    logic              item_op_reg;
    logic [ADDR_W-1:0] item_addr_reg;
    logic [TIME_W-1:0] item_now_reg;

    // Slot table
    logic [DEPTH-1:0]  used_reg;
    logic [ADDR_W-1:0] addr_mem [DEPTH];
    logic [TIME_W-1:0] seen_mem [DEPTH];
    logic [MSG_W-1:0]  msgs_mem [DEPTH];
    logic [TIME_W-1:0] pubt_mem [DEPTH];
    logic [MSG_W-1:0]  pubm_mem [DEPTH];

    // Registered read data
    logic [ADDR_W-1:0] rd_addr_reg;
    logic [TIME_W-1:0] rd_seen_reg;
    logic [MSG_W-1:0]  rd_msgs_reg;
    logic [TIME_W-1:0] rd_pubt_reg;
    logic [MSG_W-1:0]  rd_pubm_reg;

    // Walk state
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [CNT_W-1:0] used_cnt_reg, used_cnt_next;

    // Result register
    logic              res_vld_reg, res_vld_next;
    kind_t             kind_reg, kind_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [ADDR_W-1:0] eaddr_reg, eaddr_next;
    logic [MSG_W-1:0]  count_reg, count_next;
    logic [USED_W-1:0] used_out_reg, used_out_next;
    logic              last_reg, last_next;

    // Compare stage
    logic              is_frame, slot_live, scan_cmp, expired, due;
    logic              do_expire, do_publish, new_entry;
    logic [TIME_W-1:0] seen_age, pub_age;
    logic [MSG_W-1:0]  msgs_inc;

    // Table writes
    logic [IDX_W-1:0]  wr_idx;
    logic              seen_we, pub_we;
    logic [MSG_W-1:0]  msgs_wd, pubm_wd;
    logic [TIME_W-1:0] pubt_wd;

    // Configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg     <= TTL_RESET;
            pub_int_reg <= PUB_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDX_TTL: ttl_reg     <= cfg_data;
                CFG_IDX_PUB: pub_int_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_op_reg   <= op;
            item_addr_reg <= address;
            item_now_reg  <= now_ms;
        end
    end

    // Compare of the slot whose data has just been read
    always_comb
    begin
        is_frame   = (item_op_reg == OP_FRAME);
        slot_live  = used_reg[cmp_idx];
        hit        = cmd.cmp_en && is_frame && slot_live && (rd_addr_reg == item_addr_reg);
        msgs_inc   = rd_msgs_reg + MSG_W'(1);
        seen_age   = item_now_reg - rd_seen_reg;
        pub_age    = item_now_reg - rd_pubt_reg;
        expired    = (seen_age > ttl_reg);
        due        = (pub_age >= pub_int_reg) && (rd_msgs_reg != rd_pubm_reg);
        scan_cmp   = cmd.cmp_en && !is_frame && slot_live;
        do_expire  = scan_cmp && expired;
        do_publish = scan_cmp && !expired && due;
        new_entry  = cmd.finish && is_frame && free_found_reg;
    end

    // Lowest free slot and live count over the walk
    always_comb
    begin
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        used_cnt_next   = used_cnt_reg;
        if (cmd.load)
        begin
            free_found_next = 1'b0;
            free_idx_next   = '0;
            used_cnt_next   = '0;
        end
        else if (cmd.cmp_en)
        begin
            if (is_frame && !slot_live && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = cmp_idx;
            end
            if (scan_cmp && !expired)
            begin
                used_cnt_next = used_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            used_cnt_reg   <= '0;
        end
        else
        begin
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            used_cnt_reg   <= used_cnt_next;
        end
    end

    // Slot occupancy flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (new_entry)
        begin
            used_reg[free_idx_reg] <= 1'b1;
        end
        else if (do_expire)
        begin
            used_reg[cmp_idx] <= 1'b0;
        end
    end

    // Table write selection: claim at finish, else the compared slot
    always_comb
    begin
        wr_idx  = new_entry ? free_idx_reg : cmp_idx;
        seen_we = hit || new_entry;
        pub_we  = do_publish || new_entry;
        msgs_wd = new_entry ? MSG_W'(1) : msgs_inc;
        pubt_wd = new_entry ? '0 : item_now_reg;
        pubm_wd = new_entry ? '0 : rd_msgs_reg;
    end

    // Table memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (new_entry)
        begin
            addr_mem[wr_idx] <= item_addr_reg;
        end
        if (seen_we)
        begin
            seen_mem[wr_idx] <= item_now_reg;
            msgs_mem[wr_idx] <= msgs_wd;
        end
        if (pub_we)
        begin
            pubt_mem[wr_idx] <= pubt_wd;
            pubm_mem[wr_idx] <= pubm_wd;
        end
        if (cmd.rd_en)
        begin
            rd_addr_reg <= addr_mem[rd_idx];
            rd_seen_reg <= seen_mem[rd_idx];
            rd_msgs_reg <= msgs_mem[rd_idx];
            rd_pubt_reg <= pubt_mem[rd_idx];
            rd_pubm_reg <= pubm_mem[rd_idx];
        end
    end

    // Result selection
    always_comb
    begin
        res_vld_next  = 1'b0;
        kind_next     = KIND_DONE;
        slot_next     = '0;
        eaddr_next    = '0;
        count_next    = '0;
        used_out_next = '0;
        last_next     = 1'b0;
        if (hit)
        begin
            res_vld_next = 1'b1;
            kind_next    = KIND_HIT;
            slot_next    = SLOT_W'(cmp_idx);
            eaddr_next   = item_addr_reg;
            count_next   = msgs_inc;
            last_next    = 1'b1;
        end
        else if (do_expire || do_publish)
        begin
            res_vld_next = 1'b1;
            kind_next    = do_expire ? KIND_EXPIRED : KIND_PUBLISH;
            slot_next    = SLOT_W'(cmp_idx);
            eaddr_next   = rd_addr_reg;
            count_next   = rd_msgs_reg;
        end
        else if (cmd.finish)
        begin
            res_vld_next = 1'b1;
            last_next    = 1'b1;
            if (!is_frame)
            begin
                kind_next     = KIND_DONE;
                used_out_next = USED_W'(used_cnt_reg);
            end
            else if (free_found_reg)
            begin
                kind_next  = KIND_NEW;
                slot_next  = SLOT_W'(free_idx_reg);
                eaddr_next = item_addr_reg;
                count_next = MSG_W'(1);
            end
            else
            begin
                kind_next  = KIND_FULL;
                eaddr_next = item_addr_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else
        begin
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        slot_reg     <= slot_next;
        eaddr_reg    <= eaddr_next;
        count_reg    <= count_next;
        used_out_reg <= used_out_next;
        last_reg     <= last_next;
    end

    assign result_valid  = res_vld_reg;
    assign kind          = kind_reg;
    assign slot          = slot_reg;
    assign entry_address = eaddr_reg;
    assign message_count = count_reg;
    assign used_count    = used_out_reg;
    assign last          = last_reg;

    `ATT_ASSERT_NEXT(a_load_clears_result, cmd.load, !res_vld_reg, "result pending at item start")
    `ATT_ASSERT_IMPL(a_frame_single, res_vld_reg && (item_op_reg == OP_FRAME), last_reg, "frame gave more than one result")
    `ATT_ASSERT_IMPL(a_used_bound, res_vld_reg && (kind_reg == KIND_DONE), used_out_reg <= USED_W'(DEPTH), "used count above table size")

endmodule

FILE: rtl/core/aircraft_track_table.sv
// Aircraft track table top level: controller and datapath.
//
// Items are taken on start while busy is low. Each item walks the table one slot per cycle
// through the table's single read port, comparing each slot in the cycle after its read.
// A frame that hits a slot stops the walk at that slot's compare; a new entry, a dropped frame
// and every scan walk all TABLE_DEPTH slots before a final step. Results appear with
// result_valid for one cycle each, at most one per cycle, and cannot be held off; the last
// result of an item carries last. A new item may be started in the cycle that shows the
// previous item's final result. The configuration port is always ready; write it only while
// the table is idle. No clearing pass follows reset; only slot occupancy flags are reset.
module aircraft_track_table
    import att_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 op,
    input  logic [ADDR_W-1:0]    address,
    input  logic [TIME_W-1:0]    now_ms,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_data,
    output logic                 result_valid,
    output logic [KIND_W-1:0]    kind,
    output logic [SLOT_W-1:0]    slot,
    output logic [ADDR_W-1:0]    entry_address,
    output logic [MSG_W-1:0]     message_count,
    output logic [USED_W-1:0]    used_count,
    output logic                 last
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    att_cmd_t         cmd;
    logic             hit;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] cmp_idx;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    att_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .hit     (hit),
        .busy    (busy),
        .cmd     (cmd),
        .rd_idx  (rd_idx),
        .cmp_idx (cmp_idx)
    );

    att_datapath #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .rd_idx        (rd_idx),
        .cmp_idx       (cmp_idx),
        .hit           (hit),
        .op            (op),
        .address       (address),
        .now_ms        (now_ms),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_valid  (result_valid),
        .kind          (kind),
        .slot          (slot),
        .entry_address (entry_address),
        .message_count (message_count),
        .used_count    (used_count),
        .last          (last)
    );

endmodule

FILE: bench/aircraft_track_table_checker.sv
// Checker for the aircraft track table: predicts every result and compares it field by field.
`timescale 1ns / 1ps

module aircraft_track_table_checker
    import att_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic                 op,
    input  logic [ADDR_W-1:0]    address,
    input  logic [TIME_W-1:0]    now_ms,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_data,
    input  logic                 result_valid,
    input  logic [KIND_W-1:0]    kind,
    input  logic [SLOT_W-1:0]    slot,
    input  logic [ADDR_W-1:0]    entry_address,
    input  logic [MSG_W-1:0]     message_count,
    input  logic [USED_W-1:0]    used_count,
    input  logic                 last,
    output int                   fail_count,
    output int                   awaited,
    output int                   reports_checked,
    output logic [5:0]           kinds_seen
);

    typedef struct packed {
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] entry_address;
        logic [MSG_W-1:0]  message_count;
        logic [USED_W-1:0] used_count;
        logic              last;
    } report_t;

    // Reports still owed by the block, oldest first
    report_t awaited_reports[$];
    report_t owed;

    // Own copy of the registers and the track table
    logic [TIME_W-1:0] ttl;
    logic [TIME_W-1:0] pub_interval;
    logic              trk_used      [DEPTH];
    logic [ADDR_W-1:0] trk_addr      [DEPTH];
    logic [TIME_W-1:0] trk_seen      [DEPTH];
    logic [MSG_W-1:0]  trk_count     [DEPTH];
    logic [TIME_W-1:0] trk_pub_time  [DEPTH];
    logic [MSG_W-1:0]  trk_pub_count [DEPTH];

    function automatic report_t make_report(kind_t k, int s, logic [ADDR_W-1:0] a,
                                            logic [MSG_W-1:0] c, logic [USED_W-1:0] u,
                                            logic l);
        report_t r;
        r.kind          = k;
        r.slot          = s[SLOT_W-1:0];
        r.entry_address = a;
        r.message_count = c;
        r.used_count    = u;
        r.last          = l;
        return r;
    endfunction

    // Frame: hit refreshes, miss claims the lowest free slot, else dropped
    task automatic predict_frame(logic [ADDR_W-1:0] a, logic [TIME_W-1:0] t);
        int hit_idx;
        int free_idx;
        hit_idx  = -1;
        free_idx = -1;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (hit_idx < 0 && trk_used[i] && trk_addr[i] == a)
                hit_idx = i;
            if (hit_idx < 0 && !trk_used[i] && free_idx < 0)
                free_idx = i;
        end
        if (hit_idx >= 0)
        begin
            trk_seen[hit_idx]  = t;
            trk_count[hit_idx] = trk_count[hit_idx] + MSG_W'(1);
            awaited_reports.push_back(make_report(KIND_HIT, hit_idx, a, trk_count[hit_idx],
                                                  '0, 1'b1));
        end
        else if (free_idx < 0)
        begin
            awaited_reports.push_back(make_report(KIND_FULL, 0, a, '0, '0, 1'b1));
        end
        else
        begin
            trk_used[free_idx]      = 1'b1;
            trk_addr[free_idx]      = a;
            trk_seen[free_idx]      = t;
            trk_count[free_idx]     = MSG_W'(1);
            trk_pub_time[free_idx]  = '0;
            trk_pub_count[free_idx] = '0;
            awaited_reports.push_back(make_report(KIND_NEW, free_idx, a, MSG_W'(1), '0,
                                                  1'b1));
        end
    endtask

    // Scan: expire idle tracks, report those due, close with the live count
    task automatic predict_scan(logic [TIME_W-1:0] t);
        logic [USED_W-1:0] live;
        logic [TIME_W-1:0] idle_for;
        logic [TIME_W-1:0] since_pub;
        live = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (trk_used[i])
            begin
                idle_for  = t - trk_seen[i];
                since_pub = t - trk_pub_time[i];
                if (idle_for > ttl)
                begin
                    awaited_reports.push_back(make_report(KIND_EXPIRED, i, trk_addr[i],
                                                          trk_count[i], '0, 1'b0));
                    trk_used[i] = 1'b0;
                end
                else
                begin
                    live = live + USED_W'(1);
                    if (since_pub >= pub_interval && trk_count[i] != trk_pub_count[i])
                    begin
                        awaited_reports.push_back(make_report(KIND_PUBLISH, i, trk_addr[i],
                                                              trk_count[i], '0, 1'b0));
                        trk_pub_time[i]  = t;
                        trk_pub_count[i] = trk_count[i];
                    end
                end
            end
        end
        awaited_reports.push_back(make_report(KIND_DONE, 0, '0, '0, live, 1'b1));
    endtask

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl             = TTL_RESET;
            pub_interval    = PUB_RESET;
            fail_count      = 0;
            reports_checked = 0;
            kinds_seen      = '0;
            awaited_reports.delete();
            for (int i = 0; i < DEPTH; i++)
                trk_used[i] = 1'b0;
        end
        else
        begin
            // Result transfer against the oldest owed report
            if (result_valid)
            begin
                if (awaited_reports.size() == 0)
                begin
                    $error("result with none owed: kind %0d slot %0d address 0x%0h",
                           kind, slot, entry_address);
                    fail_count++;
                end
                else
                begin
                    owed = awaited_reports.pop_front();
                    check_field("kind", 32'(owed.kind), 32'(kind));
                    check_field("slot", 32'(owed.slot), 32'(slot));
                    check_field("entry_address", 32'(owed.entry_address),
                                32'(entry_address));
                    check_field("message_count", owed.message_count, message_count);
                    check_field("used_count", 32'(owed.used_count), 32'(used_count));
                    check_field("last", 32'(owed.last), 32'(last));
                    kinds_seen[owed.kind] = 1'b1;
                    reports_checked++;
                end
            end

            // Register write; unmapped indexes are ignored
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_IDX_TTL)
                    ttl = cfg_data;
                else if (cfg_index == CFG_IDX_PUB)
                    pub_interval = cfg_data;
            end

            // Item transfer
            if (start && !busy)
            begin
                if (op == OP_FRAME)
                    predict_frame(address, now_ms);
                else
                    predict_scan(now_ms);
            end
        end
        awaited = awaited_reports.size();
    end

endmodule

FILE: bench/aircraft_track_table_test.sv
// Top of the aircraft track table testbench: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module aircraft_track_table_test;
    import att_pkg::*;

    localparam int DEPTH         = DEPTH_DEFAULT;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = DEPTH + 6;
    localparam int FLEET_SIZE    = 48;
    localparam int FLEET_IDX_W   = $clog2(FLEET_SIZE);

    // Register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 op;
    logic [ADDR_W-1:0]    address;
    logic [TIME_W-1:0]    now_ms;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TIME_W-1:0]    cfg_data;
    logic                 result_valid;
    logic [KIND_W-1:0]    kind;
    logic [SLOT_W-1:0]    slot;
    logic [ADDR_W-1:0]    entry_address;
    logic [MSG_W-1:0]     message_count;
    logic [USED_W-1:0]    used_count;
    logic                 last;

    int         fail_count;
    int         awaited;
    int         reports_checked;
    logic [5:0] kinds_seen;

    int                idle_cycles = 0;
    int                burst_left  = 0;
    int                items_sent  = 0;
    int                cfg_writes  = 0;
    logic [TIME_W-1:0] clock_ms;
    logic [ADDR_W-1:0] fleet [FLEET_SIZE];

    always #5 clk = ~clk;

    aircraft_track_table #(.TABLE_DEPTH(DEPTH)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .address       (address),
        .now_ms        (now_ms),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_valid  (result_valid),
        .kind          (kind),
        .slot          (slot),
        .entry_address (entry_address),
        .message_count (message_count),
        .used_count    (used_count),
        .last          (last)
    );

    aircraft_track_table_checker #(.DEPTH(DEPTH)) track_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .address         (address),
        .now_ms          (now_ms),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .result_valid    (result_valid),
        .kind            (kind),
        .slot            (slot),
        .entry_address   (entry_address),
        .message_count   (message_count),
        .used_count      (used_count),
        .last            (last),
        .fail_count      (fail_count),
        .awaited         (awaited),
        .reports_checked (reports_checked),
        .kinds_seen      (kinds_seen)
    );

    // Watchdog: any transfer on any channel counts as progress
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("no transfer for %0d cycles, giving up", IDLE_LIMIT);
            $display("aircraft_track_table_test failed");
            $finish;
        end
    end

    // One item transfer; the sender runs in bursts separated by random gaps
    task automatic send_item(logic o, logic [ADDR_W-1:0] a, logic [TIME_W-1:0] t);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 45);
            if (gap > 0)
            begin
                @(negedge clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        start   <= 1'b1;
        op      <= o;
        address <= a;
        now_ms  <= t;
        do @(posedge clk); while (busy);
        items_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Stop sending and wait until every owed result has come and the block is idle
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (awaited != 0 || busy)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        burst_left = 0;
    endtask

    // Mixed traffic: mostly frames from a known fleet, some strangers, some scans
    task automatic traffic(int n, int step_max, int fleet_used, int scan_pct);
        for (int k = 0; k < n; k++)
        begin
            clock_ms = clock_ms + $urandom_range(0, step_max);
            if ($urandom_range(1, 100) <= scan_pct)
                send_item(OP_SCAN, ADDR_W'($urandom), clock_ms);
            else if ($urandom_range(0, 9) == 0)
                send_item(OP_FRAME, ADDR_W'($urandom), clock_ms);
            else
                send_item(OP_FRAME,
                          fleet[FLEET_IDX_W'($urandom_range(0, fleet_used - 1))],
                          clock_ms);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        op        = OP_FRAME;
        address   = '0;
        now_ms    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_IDX_TTL;
        cfg_data  = '0;
        fleet[0]  = '0;
        fleet[1]  = '1;
        for (int i = 2; i < FLEET_SIZE; i++)
            fleet[i] = ADDR_W'($urandom);
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, reset register values: claim, hit, publish, expiry, slot reuse
        send_item(OP_FRAME, 24'h000000, 32'd0);
        send_item(OP_FRAME, 24'hFFFFFF, 32'd5);
        send_item(OP_FRAME, 24'h000000, 32'd10);
        send_item(OP_SCAN,  24'hFFFFFF, 32'd10);
        send_item(OP_SCAN,  24'h000000, 32'd1000);
        send_item(OP_SCAN,  24'h123456, 32'd1999);
        send_item(OP_FRAME, 24'h000000, 32'd2000);
        send_item(OP_SCAN,  24'h000000, 32'd2000);
        send_item(OP_SCAN,  24'h000000, 32'd60005);
        send_item(OP_SCAN,  24'h000000, 32'd60006);
        send_item(OP_FRAME, 24'hABCDEF, 32'd60006);
        send_item(OP_FRAME, 24'h555555, 32'd60006);
        send_item(OP_FRAME, 24'hABCDEF, 32'd60100);
        settle();

        // Writes to unmapped indexes must leave the registers alone
        write_reg(CFG_IDX_SPARE_LO, $urandom);
        write_reg(CFG_IDX_SPARE_HI, $urandom);
        send_item(OP_SCAN, 24'h000000, 32'd62010);
        send_item(OP_FRAME, 24'hAAAAAA, 32'd62010);
        send_item(OP_SCAN, 24'h000000, 32'd62010);
        settle();

        // Zero TTL and zero interval: anything not seen this instant expires
        write_reg(CFG_IDX_TTL, 32'd0);
        write_reg(CFG_IDX_PUB, 32'd0);
        clock_ms = 32'd62010;
        traffic(40, 3, 12, 30);
        settle();

        // Largest TTL and interval: nothing expires, overflow drops frames
        write_reg(CFG_IDX_TTL, '1);
        write_reg(CFG_IDX_PUB, '1);
        for (int k = 0; k < 36; k++)
        begin
            clock_ms = clock_ms + $urandom_range(0, 3);
            send_item(OP_FRAME, ADDR_W'($urandom), clock_ms);
        end
        send_item(OP_SCAN, ADDR_W'($urandom), 32'hFFFF_FFFF);
        traffic(10, 50, FLEET_SIZE, 20);
        settle();

        // Mass expiry of a full table
        write_reg(CFG_IDX_TTL, 32'd0);
        clock_ms = clock_ms + 1;
        send_item(OP_SCAN, ADDR_W'($urandom), clock_ms);
        settle();

        // Moderate settings with the time stamp wrapping through zero
        write_reg(CFG_IDX_TTL, $urandom_range(100, 3000));
        write_reg(CFG_IDX_PUB, $urandom_range(10, 800));
        clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 5000);
        traffic(30, 200, 40, 20);
        settle();

        // Arbitrary register values and time stamps
        write_reg(CFG_IDX_TTL, $urandom);
        write_reg(CFG_IDX_PUB, $urandom);
        write_reg(CFG_IDX_SPARE_HI, $urandom);
        clock_ms = $urandom;
        traffic(30, 1 << 24, 24, 25);
        settle();

        $display("%0d items and %0d register writes sent, %0d results checked",
                 items_sent, cfg_writes, reports_checked);
        $display("result kinds seen, bit 0 hit up to bit 5 scan done: %b", kinds_seen);
        if (fail_count == 0 && awaited == 0)
            $display("aircraft_track_table_test passed");
        else
            $display("aircraft_track_table_test failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/att_pkg.sv
rtl/core/att_ctrl.sv
rtl/core/att_datapath.sv
rtl/core/aircraft_track_table.sv
bench/aircraft_track_table_checker.sv
bench/aircraft_track_table_test.sv
